FILE: design/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg: task dispatch scheduler shared types
// Beat payloads, policy codes, function codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tds_pkg;

  localparam int unsigned DefTaskSlots = 8;
  localparam int unsigned DataW        = 8;
  localparam int unsigned SlotFieldW   = 3;
  localparam int unsigned PolicyW      = 3;
  localparam int unsigned CfgIdxW      = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_POLICY  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_QUANTUM = 1'b1;

  // item function codes
  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  typedef enum logic [PolicyW-1:0] {
    POL_FCFS    = 3'd0,
    POL_SJF     = 3'd1,
    POL_PRIO    = 3'd2,
    POL_RR      = 3'd3,
    POL_PRIO_RR = 3'd4
  } policy_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BEST   = 5'b00010,
    ST_PICK   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } seq_state_e;

  typedef struct packed {
    logic                  func;
    logic [SlotFieldW-1:0] task_slot;
    logic [DataW-1:0]      task_priority;
    logic [DataW-1:0]      task_burst;
  } item_t;

  typedef struct packed {
    logic                  dispatch_valid;
    logic [SlotFieldW-1:0] chosen_slot;
    logic [DataW-1:0]      run_length;
    logic                  task_finished;
    logic                  all_finished;
  } result_t;

  // table write controls (address travels beside it)
  typedef struct packed {
    logic             burst_we;
    logic             prio_we;
    logic [DataW-1:0] burst;
    logic [DataW-1:0] prio;
  } tbl_wr_t;

endpackage

`default_nettype wire

FILE: design/tds_table.sv
// ----------------------------------------------------------------------------
// tds_table: task slot table
// Priority and remaining burst per slot, one write and one read port, plus a
// flag per slot that marks an unfinished task.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_table #(
  parameter int unsigned NumSlots = tds_pkg::DefTaskSlots,
  parameter int unsigned SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  tds_pkg::tbl_wr_t     wr_i,
  input  wire  [SlotW-1:0]           wr_addr_i,
  input  wire  [SlotW-1:0]           rd_addr_i,
  output logic [tds_pkg::DataW-1:0]  rd_burst_o,
  output logic [tds_pkg::DataW-1:0]  rd_prio_o,
  output logic [NumSlots-1:0]        busy_slots_o
);

  logic [tds_pkg::DataW-1:0] burst_q [NumSlots];
  logic [tds_pkg::DataW-1:0] prio_q  [NumSlots];
  logic [NumSlots-1:0]       pend_q;

  // payload entries are only used where the pending flag is set
  always_ff @(posedge clk_i) begin
    if (wr_i.burst_we) begin
      burst_q[wr_addr_i] <= wr_i.burst;
    end
    if (wr_i.prio_we) begin
      prio_q[wr_addr_i] <= wr_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (wr_i.burst_we) begin
      pend_q[wr_addr_i] <= (wr_i.burst != '0);
    end
  end

  assign rd_burst_o   = burst_q[rd_addr_i];
  assign rd_prio_o    = prio_q[rd_addr_i];
  assign busy_slots_o = pend_q;

endmodule

`default_nettype wire

FILE: design/tds_sequencer.sv
// ----------------------------------------------------------------------------
// tds_sequencer: slot scan sequencer
// Walks the table one slot a cycle through a shared compare unit, then
// charges the granted run length to the chosen slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_sequencer #(
  parameter int unsigned NumSlots = tds_pkg::DefTaskSlots,
  parameter int unsigned SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  tds_pkg::item_t         item_i,
  input  wire  [tds_pkg::PolicyW-1:0]  policy_i,
  input  wire  [tds_pkg::DataW-1:0]    quantum_i,
  input  wire  [tds_pkg::DataW-1:0]    rd_burst_i,
  input  wire  [tds_pkg::DataW-1:0]    rd_prio_i,
  input  wire  [NumSlots-1:0]          busy_slots_i,
  output logic [SlotW-1:0]             rd_addr_o,
  output tds_pkg::tbl_wr_t             wr_o,
  output logic [SlotW-1:0]             wr_addr_o,
  output logic                         busy_o,
  output logic                         done_o,
  output tds_pkg::result_t             res_o
);

  localparam logic [SlotW-1:0] LastSlot = SlotW'(NumSlots - 1);

  tds_pkg::seq_state_e state_q, state_d;
  tds_pkg::policy_e    pol;
  logic [SlotW-1:0]    idx_q, idx_d, cnt_q, cnt_d, pick_q, pick_d, ptr_q, ptr_d;
  logic [SlotW-1:0]    rr_start;
  logic                found_q, found_d;
  logic [tds_pkg::DataW-1:0] key_q, key_d;
  tds_pkg::result_t    res_q, res_d;
  logic                rr, cand, slot_ok;
  logic                cmp_gt, cmp_lt, cmp_eq;
  logic [tds_pkg::DataW-1:0] cmp_a, quant, run;

  always_comb begin
    unique case (policy_i)
      tds_pkg::POL_SJF:     pol = tds_pkg::POL_SJF;
      tds_pkg::POL_PRIO:    pol = tds_pkg::POL_PRIO;
      tds_pkg::POL_RR:      pol = tds_pkg::POL_RR;
      tds_pkg::POL_PRIO_RR: pol = tds_pkg::POL_PRIO_RR;
      default:              pol = tds_pkg::POL_FCFS;
    endcase
  end

  assign rr       = (pol == tds_pkg::POL_RR) || (pol == tds_pkg::POL_PRIO_RR);
  assign rr_start = (ptr_q == LastSlot) ? '0 : ptr_q + 1'b1;
  assign slot_ok  = (int'(item_i.task_slot) < NumSlots);

  // shared compare unit
  assign cmp_a  = (pol == tds_pkg::POL_SJF) ? rd_burst_i : rd_prio_i;
  assign cmp_gt = cmp_a > key_q;
  assign cmp_lt = cmp_a < key_q;
  assign cmp_eq = cmp_a == key_q;

  always_comb begin
    case (pol)
      tds_pkg::POL_SJF:     cand = !found_q || cmp_lt;
      tds_pkg::POL_PRIO:    cand = !found_q || cmp_gt;
      tds_pkg::POL_PRIO_RR: cand = !found_q && cmp_eq;
      default:              cand = !found_q;
    endcase
    cand = cand && busy_slots_i[idx_q];
  end

  assign quant = (quantum_i == '0) ? tds_pkg::DataW'(1) : quantum_i;
  assign run   = (rr && (quant < rd_burst_i)) ? quant : rd_burst_i;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    pick_d    = pick_q;
    ptr_d     = ptr_q;
    found_d   = found_q;
    key_d     = key_q;
    res_d     = res_q;
    wr_o      = '0;
    wr_addr_o = idx_q;
    rd_addr_o = idx_q;

    unique case (state_q)
      tds_pkg::ST_IDLE: begin
        if (start_i) begin
          res_d   = '0;
          found_d = 1'b0;
          cnt_d   = '0;
          idx_d   = rr ? rr_start : '0;
          if (item_i.func == tds_pkg::FUNC_LOAD) begin
            wr_o.burst_we = slot_ok;
            wr_o.prio_we  = slot_ok;
            wr_o.burst    = item_i.task_burst;
            wr_o.prio     = item_i.task_priority;
            wr_addr_o     = SlotW'(item_i.task_slot);
            state_d       = tds_pkg::ST_DONE;
          end else if (busy_slots_i == '0) begin
            state_d = tds_pkg::ST_DONE;
          end else if (pol == tds_pkg::POL_PRIO_RR) begin
            state_d = tds_pkg::ST_BEST;
          end else begin
            state_d = tds_pkg::ST_PICK;
          end
        end
      end
      tds_pkg::ST_BEST: begin
        // find the top priority among pending slots
        if (busy_slots_i[idx_q] && (!found_q || cmp_gt)) begin
          key_d   = rd_prio_i;
          found_d = 1'b1;
        end
        idx_d = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          found_d = 1'b0;
          cnt_d   = '0;
          idx_d   = rr_start;
          state_d = tds_pkg::ST_PICK;
        end
      end
      tds_pkg::ST_PICK: begin
        if (cand) begin
          pick_d  = idx_q;
          found_d = 1'b1;
          if (pol == tds_pkg::POL_SJF || pol == tds_pkg::POL_PRIO) begin
            key_d = cmp_a;
          end
        end
        idx_d = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          state_d = tds_pkg::ST_UPDATE;
        end
      end
      tds_pkg::ST_UPDATE: begin
        rd_addr_o              = pick_q;
        wr_addr_o              = pick_q;
        wr_o.burst_we          = 1'b1;
        wr_o.burst             = rd_burst_i - run;
        res_d.dispatch_valid   = 1'b1;
        res_d.chosen_slot      = tds_pkg::SlotFieldW'(pick_q);
        res_d.run_length       = run;
        res_d.task_finished    = (rd_burst_i == run);
        if (rr) begin
          ptr_d = pick_q;
        end
        state_d = tds_pkg::ST_DONE;
      end
      tds_pkg::ST_DONE: begin
        state_d = tds_pkg::ST_IDLE;
      end
      default: begin
        state_d = tds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tds_pkg::ST_IDLE;
      ptr_q   <= LastSlot;
      idx_q   <= '0;
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
    key_q  <= key_d;
    res_q  <= res_d;
  end

  assign busy_o = (state_q != tds_pkg::ST_IDLE);
  assign done_o = (state_q == tds_pkg::ST_DONE);

  // all_finished reflects the table after this item's write
  always_comb begin
    res_o              = res_q;
    res_o.all_finished = (busy_slots_i == '0);
  end

endmodule

`default_nettype wire

FILE: design/task_dispatch_scheduler.sv
// ----------------------------------------------------------------------------
// task_dispatch_scheduler: task slot table with policy-driven dispatch
//
//   port group        dir  handshake          beat
//   item              in   start_i / busy_o   in_i (tds_pkg::item_t)
//   result            out  done_o             res_o (tds_pkg::result_t)
//   config            in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// A load beat writes the table and goes straight to the result. A dispatch
// beat scans one slot per cycle through a single compare unit (twice under
// priority round robin: top priority first, then the pick), then charges the
// chosen slot; with no pending task it goes straight to the result.
// busy_o stays high through the result beat and drops the cycle after, so the
// next item is taken once busy_o is low.
// Reset empties the table (all tasks finished), selects first come first
// served with quantum 1, and points round robin at slot 0 next.
// The result cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module task_dispatch_scheduler #(
  parameter int unsigned TaskSlots = tds_pkg::DefTaskSlots
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  output logic                          busy_o,
  input  wire  tds_pkg::item_t          in_i,
  output logic                          done_o,
  output tds_pkg::result_t              res_o,
  input  wire                           cfg_we_i,
  input  wire  [tds_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [tds_pkg::DataW-1:0]     cfg_data_i
);

  localparam int unsigned SlotW = (TaskSlots > 1) ? $clog2(TaskSlots) : 1;

  logic [tds_pkg::PolicyW-1:0] policy_q;
  logic [tds_pkg::DataW-1:0]   quantum_q;
  logic                        accept;

  tds_pkg::tbl_wr_t            tbl_wr;
  logic [SlotW-1:0]            wr_addr, rd_addr;
  logic [tds_pkg::DataW-1:0]   rd_burst, rd_prio;
  logic [TaskSlots-1:0]        busy_slots;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= tds_pkg::POL_FCFS;
      quantum_q <= tds_pkg::DataW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tds_pkg::REG_POLICY:  policy_q  <= cfg_data_i[tds_pkg::PolicyW-1:0];
        tds_pkg::REG_QUANTUM: quantum_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = start_i && !busy_o;

  tds_table #(
    .NumSlots (TaskSlots),
    .SlotW    (SlotW)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (tbl_wr),
    .wr_addr_i    (wr_addr),
    .rd_addr_i    (rd_addr),
    .rd_burst_o   (rd_burst),
    .rd_prio_o    (rd_prio),
    .busy_slots_o (busy_slots)
  );

  tds_sequencer #(
    .NumSlots (TaskSlots),
    .SlotW    (SlotW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .item_i       (in_i),
    .policy_i     (policy_q),
    .quantum_i    (quantum_q),
    .rd_burst_i   (rd_burst),
    .rd_prio_i    (rd_prio),
    .busy_slots_i (busy_slots),
    .rd_addr_o    (rd_addr),
    .wr_o         (tbl_wr),
    .wr_addr_o    (wr_addr),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire
